FILE: src/adw_pkg.sv
// Shared types, constants and lookup tables of the audio distortion waveshaper.
// The tanh and sine tables are built at elaboration from integer series.
// Depends on nothing; the interfaces and the top level import it.
package adw_pkg;

  localparam int TABLE_ADDR_BITS = 8;
  localparam int TBL_SEGS        = 1 << TABLE_ADDR_BITS;
  localparam int TBL_SIZE        = TBL_SEGS + 1;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [MODE_W-1:0]          mode_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_W-1:0]           cfg_data_t;

  localparam mode_t MODE_SOFT = 2'd0;
  localparam mode_t MODE_HARD = 2'd1;
  localparam mode_t MODE_TANH = 2'd2;
  localparam mode_t MODE_FUZZ = 2'd3;

  localparam cfg_idx_t REG_SHAPE_MODE = 2'd0;
  localparam cfg_idx_t REG_DRIVE_GAIN = 2'd1;

  localparam gain_t GAIN_RESET  = 16'd4096;
  localparam int    DRIVE_SHIFT = 12;

  // Magnitude of the driven sample, Q.15, up to 16.0.
  localparam int ABS_W = 20;
  localparam logic [ABS_W-1:0] DRIVE_LIM = 20'd524288;
  localparam logic [ABS_W-1:0] HARD_LIM  = 20'd13107;
  localparam logic [ABS_W-1:0] FUZZ_TH   = 20'd29491;
  localparam logic [ABS_W-1:0] ONE_Q15   = 20'd32768;

  localparam int TANH_SPAN_BITS = 18;
  localparam int SINE_SPAN_BITS = 15;
  localparam int TANH_SHIFT     = TANH_SPAN_BITS - TABLE_ADDR_BITS;
  localparam int SINE_SHIFT     = SINE_SPAN_BITS - TABLE_ADDR_BITS;
  localparam int FRAC_W         = TANH_SHIFT;
  localparam int IDX_W          = TABLE_ADDR_BITS + 1;
  localparam int ROM_W          = 17;

  typedef logic [ROM_W-1:0] rom_t [TBL_SIZE];
  typedef longint unsigned  u64_t;

  localparam longint Q30_ONE   = 64'sd1 <<< 30;
  localparam longint E_INV_Q30 = 64'sd395007542;

  // Restoring long division, used only while the tables are built.
  function automatic u64_t udiv(input u64_t num, input u64_t den);
    u64_t q;
    u64_t rem;
    begin
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
        rem = {rem[62:0], num[i]};
        if (rem >= den) begin
          rem  = rem - den;
          q[i] = 1'b1;
        end
      end
      return q;
    end
  endfunction

  // sin(x) for x in Q30 within [0, 1], result in Q1.15.
  function automatic int sine_q15(input longint x);
    longint x2;
    longint term;
    longint sum;
    begin
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 12; k++) begin
        term = longint'(udiv(u64_t'((term * x2) >>> 30),
                             u64_t'((2 * k) * (2 * k + 1))));
        sum  = ((k & 1) == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      return int'((sum + (64'sd1 <<< 14)) >>> 15);
    end
  endfunction

  // tanh(x) for x in Q30 within [0, 8], result in Q1.15 (may reach 32768).
  function automatic int tanh_q15(input longint x);
    longint t;
    longint n;
    longint f;
    longint term;
    longint e;
    longint num;
    longint den;
    begin
      t    = 2 * x;
      n    = t >>> 30;
      f    = t & (Q30_ONE - 1);
      term = Q30_ONE;
      e    = Q30_ONE;
      for (int k = 1; k <= 16; k++) begin
        term = longint'(udiv(u64_t'((term * f) >>> 30), u64_t'(k)));
        e    = ((k & 1) == 1) ? e - term : e + term;
      end
      for (int k = 0; k < 16; k++) begin
        if (longint'(k) < n) e = (e * E_INV_Q30) >>> 30;
      end
      if (e < 0) e = 0;
      if (e > Q30_ONE) e = Q30_ONE;
      num = (Q30_ONE - e) <<< 15;
      den = Q30_ONE + e;
      return int'(udiv(u64_t'(num + (den >>> 1)), u64_t'(den)));
    end
  endfunction

  function automatic rom_t build_sine_rom();
    rom_t r;
    begin
      for (int i = 0; i < TBL_SIZE; i++) begin
        r[i] = ROM_W'(sine_q15(longint'(i) <<< (30 - TABLE_ADDR_BITS)));
      end
      return r;
    end
  endfunction

  function automatic rom_t build_tanh_rom();
    rom_t r;
    begin
      for (int i = 0; i < TBL_SIZE; i++) begin
        r[i] = ROM_W'(tanh_q15(longint'(i) <<< (33 - TABLE_ADDR_BITS)));
      end
      return r;
    end
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();
  localparam rom_t TANH_ROM = build_tanh_rom();

endpackage

FILE: src/adw_if.sv
// Valid/ready stream interfaces for the waveshaper's sample input and output.
// Depends on adw_pkg for the sample type.
interface adw_in_if;
  logic             valid;
  logic             ready;
  adw_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface adw_out_if;
  logic             valid;
  logic             ready;
  adw_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: src/audio_distortion_waveshaper_top.sv
// Audio distortion waveshaper: drive gain, then soft clip, hard clip, tanh or fuzz.
// One word in, one word out, five register stages; each stage holds a valid bit and
// advances when the stage after it is empty or moving. A new sample is taken every
// clock while the output side keeps up, and each sample passes through every stage in
// turn and waits there while the output is stalled. The stages are: the 16x16 drive
// multiply, rounding and limiting, table lookup and squaring, the interpolation and
// cube multiplies, and the final rounding and saturation into the output register.
// Configuration writes are taken any cycle and belong while no sample is in flight.
// Depends on adw_pkg and the stream interfaces in adw_if.sv.
module audio_distortion_waveshaper_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  adw_pkg::cfg_idx_t   wr_index,
  input  adw_pkg::cfg_data_t  wr_data,
  adw_in_if.sink              up,
  adw_out_if.source           down
);
  import adw_pkg::*;

  localparam int P_W  = SAMPLE_W + GAIN_W + 1;
  localparam int D_W  = ROM_W + 1;
  localparam int DP_W = D_W + FRAC_W + 1;
  localparam int Y_W  = 20;

  // Configuration registers.
  mode_t shape_mode;
  gain_t drive_gain;

  // Stage valid bits and enables.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  // Stage payloads.
  logic signed [P_W-1:0] p1;
  logic                  neg2;
  logic [ABS_W-1:0]      a2;
  logic                  neg3, flag3;
  logic [15:0]           lo3;
  logic [31:0]           sq3;
  logic [ROM_W-1:0]      t0_3, t1_3;
  logic [FRAC_W-1:0]     frac3;
  logic                  neg4, flag4;
  logic [15:0]           lo4;
  logic [47:0]           cube4;
  logic [ROM_W-1:0]      t0_4;
  logic signed [DP_W-1:0] dprod4;
  sample_t               y5;

  // Next values.
  logic [31:0]           p_mag, p_rnd;
  logic [ABS_W-1:0]      r2, a2_next;
  logic                  flag3_next;
  logic [15:0]           lo3_next;
  logic [ABS_W-1:0]      af;
  logic [IDX_W-1:0]      idx, idx_up;
  logic [FRAC_W-1:0]     frac3_next;
  logic signed [D_W-1:0] d3;
  logic [48:0]           cube_rnd;
  logic [17:0]           cr;
  logic signed [DP_W-1:0] ri;
  logic signed [Y_W-1:0] y_pos, y_neg, diff;
  sample_t               y5_next;

  function automatic logic signed [DP_W-1:0] round_shift(
      input logic signed [DP_W-1:0] v, input int k);
    logic [DP_W-1:0] mag;
    logic [DP_W-1:0] half;
    logic [DP_W-1:0] r;
    begin
      mag  = v[DP_W-1] ? DP_W'(-v) : DP_W'(v);
      half = DP_W'(1) << (k - 1);
      r    = (mag + half) >> k;
      return v[DP_W-1] ? -$signed(r) : $signed(r);
    end
  endfunction

  assign en5 = !v5 || down.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign up.ready        = en1;
  assign down.valid      = v5;
  assign down.sample_out = y5;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= MODE_SOFT;
      drive_gain <= GAIN_RESET;
    end else if (wr_en) begin
      if (wr_index == REG_SHAPE_MODE) shape_mode <= wr_data[MODE_W-1:0];
      if (wr_index == REG_DRIVE_GAIN) drive_gain <= wr_data[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= up.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Drive: round half away from zero to Q.15, then limit to 16.0.
  always_comb begin
    p_mag   = p1[P_W-1] ? 32'(-p1) : 32'(p1);
    p_rnd   = p_mag + (32'd1 << (DRIVE_SHIFT - 1));
    r2      = ABS_W'(p_rnd >> DRIVE_SHIFT);
    a2_next = (r2 > DRIVE_LIM) ? DRIVE_LIM : r2;
  end

  // Shaper setup. The soft clip above 2.0 always lands on the negative rail,
  // so only magnitudes below 2.0 need the cube.
  always_comb begin
    af         = (a2 > FUZZ_TH) ? ONE_Q15 : a2;
    flag3_next = 1'b0;
    lo3_next   = a2[15:0];
    idx        = IDX_W'(a2[TANH_SPAN_BITS-1:TANH_SHIFT]);
    frac3_next = a2[TANH_SHIFT-1:0];
    unique case (shape_mode)
      MODE_SOFT: flag3_next = (a2[ABS_W-1:16] != '0);
      MODE_HARD: lo3_next   = (a2 > HARD_LIM) ? HARD_LIM[15:0] : a2[15:0];
      MODE_TANH: flag3_next = (a2[ABS_W-1:TANH_SPAN_BITS] != '0);
      MODE_FUZZ: begin
        idx        = IDX_W'(af >> SINE_SHIFT);
        frac3_next = FRAC_W'(af[SINE_SHIFT-1:0]);
      end
      default: flag3_next = 1'b0;
    endcase
    idx_up = (idx == IDX_W'(TBL_SEGS)) ? idx : idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en1) p1 <= up.sample_in * $signed({1'b0, drive_gain});
    if (en2) begin
      neg2 <= p1[P_W-1];
      a2   <= a2_next;
    end
    if (en3) begin
      neg3  <= neg2;
      flag3 <= flag3_next;
      lo3   <= lo3_next;
      sq3   <= a2[15:0] * a2[15:0];
      frac3 <= frac3_next;
      t0_3  <= (shape_mode == MODE_FUZZ) ? SINE_ROM[idx] : TANH_ROM[idx];
      t1_3  <= (shape_mode == MODE_FUZZ) ? SINE_ROM[idx_up] : TANH_ROM[idx_up];
    end
    if (en4) begin
      neg4   <= neg3;
      flag4  <= flag3;
      lo4    <= lo3;
      t0_4   <= t0_3;
      cube4  <= sq3 * lo3;
      dprod4 <= d3 * $signed({1'b0, frac3});
    end
    if (en5) y5 <= y5_next;
  end

  assign d3 = $signed({1'b0, t1_3}) - $signed({1'b0, t0_3});

  // Final rounding, sign restore and saturation.
  always_comb begin
    cube_rnd = {1'b0, cube4} + (49'd1 << 30);
    cr       = cube_rnd[48:31];
    diff     = $signed({4'b0, lo4}) - $signed({2'b0, cr});
    ri       = (shape_mode == MODE_FUZZ) ? round_shift(dprod4, SINE_SHIFT)
                                         : round_shift(dprod4, TANH_SHIFT);
    y_pos    = '0;
    unique case (shape_mode)
      MODE_SOFT: begin
        if (flag4 || diff < -20'sd32768) y_pos = -20'sd32768;
        else if (diff > 20'sd32768)      y_pos = 20'sd32768;
        else                             y_pos = diff;
      end
      MODE_HARD: y_pos = $signed({4'b0, lo4});
      MODE_TANH: y_pos = flag4 ? 20'sd32768 : $signed({3'b0, t0_4}) + Y_W'(ri);
      MODE_FUZZ: y_pos = $signed({3'b0, t0_4}) + Y_W'(ri);
      default:   y_pos = '0;
    endcase
    y_neg = neg4 ? -y_pos : y_pos;
    if (y_neg > 20'sd32767)       y5_next = 16'sh7fff;
    else if (y_neg < -20'sd32768) y5_next = 16'sh8000;
    else                          y5_next = y_neg[SAMPLE_W-1:0];
  end

  a_take_fills_first: assert property (@(posedge clk) disable iff (rst)
      up.valid && up.ready |=> v1)
    else $error("accepted word did not enter the first stage");

  a_drive_limit: assert property (@(posedge clk) disable iff (rst)
      v2 |-> a2 <= DRIVE_LIM)
    else $error("driven magnitude beyond 16.0");

  a_bubble_fill: assert property (@(posedge clk) disable iff (rst)
      v4 && !v5 |=> v5)
    else $error("word lost between the last two stages");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
      !v1 |-> up.ready)
    else $error("input stalled while the first stage is empty");

endmodule
